// ===== hdl/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants
// Widths of the distance datapath and the beat carried by the root stages.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int CW = 33;   // coordinate difference, signed
    localparam int PW = 66;   // product of two differences
    localparam int QW = 136;  // radicand, remainder and trial term
    localparam int AW = 100;  // root times divisor
    localparam int RW = 34;   // root bits
    localparam int DW = 33;   // distance output

    localparam logic [1:0] PART_DEGEN = 2'd0;
    localparam logic [1:0] PART_START = 2'd1;
    localparam logic [1:0] PART_END   = 2'd2;
    localparam logic [1:0] PART_MID   = 2'd3;

    typedef struct packed {
        logic          valid;
        logic [1:0]    part;
        logic [QW-1:0] rem;
        logic [AW-1:0] acc;
        logic [PW-1:0] m;
        logic [RW-1:0] root;
    } t_root;

endpackage

// ===== hdl/point_segment_distance_top.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_top: 2D point to segment distance
// Exact truncated distance from a point to a closed segment, with the part
// of the segment that is nearest.
// Throughput: one beat per cycle; busy is high only in reset, no stalls.
// Latency is set by 6 arithmetic stages and 34 one-bit square root stages.
// Reset (synchronous, active low) clears all valid bits; data is dropped.
// ----------------------------------------------------------------------------
module point_segment_distance_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [31:0]        i_point_x,
    input  logic signed [31:0]        i_point_y,
    input  logic signed [31:0]        i_start_x,
    input  logic signed [31:0]        i_start_y,
    input  logic signed [31:0]        i_end_x,
    input  logic signed [31:0]        i_end_y,
    output logic                      o_valid,
    output logic [pds_pkg::DW-1:0]    o_distance,
    output logic [1:0]                o_nearest_part
);

    localparam int CW = pds_pkg::CW;
    localparam int PW = pds_pkg::PW;
    localparam int LATENCY = 6 + pds_pkg::RW;

    // stage 1: differences
    logic r1_valid, r1_degen;
    logic signed [CW-1:0] r1_dx, r1_dy, r1_ux, r1_uy, r1_vx, r1_vy;
    // stage 2: products
    logic r2_valid, r2_degen;
    logic signed [PW-1:0] r2_dxdx, r2_dydy, r2_uxdx, r2_uydy, r2_uxdy, r2_uydx;
    logic signed [PW-1:0] r2_uxux, r2_uyuy, r2_vxvx, r2_vyvy;
    // stage 3: sums
    logic r3_valid, r3_degen;
    logic [PW-1:0] r3_len2, r3_du, r3_dv;
    logic signed [PW:0] r3_dot, r3_cross;
    // stage 4: case decision
    logic r4_valid;
    logic [1:0] r4_part, n4_part;
    logic [PW-1:0] r4_qpt, r4_cmag, r4_len2, n4_qpt;
    logic [PW:0] cross_abs;
    // stage 5: square of the cross magnitude, in halves
    logic r5_valid;
    logic [1:0] r5_part;
    logic [PW-1:0] r5_hh, r5_hl, r5_ll, r5_qpt, r5_len2;
    logic [CW-1:0] hi_half, lo_half;
    // stage 6: radicand and divisor
    pds_pkg::t_root r6_root;
    pds_pkg::t_root w_chain [0:pds_pkg::RW];

    assign busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_degen <= (i_end_x == i_start_x) && (i_end_y == i_start_y);
        r1_dx <= CW'(i_end_x) - CW'(i_start_x);
        r1_dy <= CW'(i_end_y) - CW'(i_start_y);
        r1_ux <= CW'(i_point_x) - CW'(i_start_x);
        r1_uy <= CW'(i_point_y) - CW'(i_start_y);
        r1_vx <= CW'(i_point_x) - CW'(i_end_x);
        r1_vy <= CW'(i_point_y) - CW'(i_end_y);
    end

    always_ff @(posedge i_clk) begin
        r2_degen <= r1_degen;
        r2_dxdx  <= PW'(r1_dx) * PW'(r1_dx);
        r2_dydy  <= PW'(r1_dy) * PW'(r1_dy);
        r2_uxdx  <= PW'(r1_ux) * PW'(r1_dx);
        r2_uydy  <= PW'(r1_uy) * PW'(r1_dy);
        r2_uxdy  <= PW'(r1_ux) * PW'(r1_dy);
        r2_uydx  <= PW'(r1_uy) * PW'(r1_dx);
        r2_uxux  <= PW'(r1_ux) * PW'(r1_ux);
        r2_uyuy  <= PW'(r1_uy) * PW'(r1_uy);
        r2_vxvx  <= PW'(r1_vx) * PW'(r1_vx);
        r2_vyvy  <= PW'(r1_vy) * PW'(r1_vy);
    end

    always_ff @(posedge i_clk) begin
        r3_degen <= r2_degen;
        r3_len2  <= $unsigned(r2_dxdx) + $unsigned(r2_dydy);
        r3_du    <= $unsigned(r2_uxux) + $unsigned(r2_uyuy);
        r3_dv    <= $unsigned(r2_vxvx) + $unsigned(r2_vyvy);
        r3_dot   <= (PW + 1)'(r2_uxdx) + (PW + 1)'(r2_uydy);
        r3_cross <= (PW + 1)'(r2_uxdy) - (PW + 1)'(r2_uydx);
    end

    // ends win only strictly outside; t of exactly 0 or 1 stays interior
    always_comb begin
        cross_abs = r3_cross[PW] ? $unsigned(-r3_cross) : $unsigned(r3_cross);
        if (r3_degen) begin
            n4_part = pds_pkg::PART_DEGEN;
            n4_qpt  = r3_du;
        end else if (r3_dot < 0) begin
            n4_part = pds_pkg::PART_START;
            n4_qpt  = r3_du;
        end else if (r3_dot > $signed({1'b0, r3_len2})) begin
            n4_part = pds_pkg::PART_END;
            n4_qpt  = r3_dv;
        end else begin
            n4_part = pds_pkg::PART_MID;
            n4_qpt  = r3_du;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_part <= n4_part;
        r4_qpt  <= n4_qpt;
        r4_cmag <= cross_abs[PW-1:0];
        r4_len2 <= r3_len2;
    end

    assign hi_half = r4_cmag[PW-1:CW];
    assign lo_half = r4_cmag[CW-1:0];

    always_ff @(posedge i_clk) begin
        r5_part <= r4_part;
        r5_qpt  <= r4_qpt;
        r5_len2 <= r4_len2;
        r5_hh   <= PW'(hi_half) * PW'(hi_half);
        r5_hl   <= PW'(hi_half) * PW'(lo_half);
        r5_ll   <= PW'(lo_half) * PW'(lo_half);
    end

    // interior: root of cross^2 / len2; ends and degenerate: plain root with divisor one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_root.valid <= 1'b0;
        end else begin
            r6_root.valid <= r5_valid;
        end
        r6_root.part <= r5_part;
        r6_root.acc  <= '0;
        r6_root.root <= '0;
        if (r5_part == pds_pkg::PART_MID) begin
            r6_root.rem <= (pds_pkg::QW'(r5_hh) << (2 * CW))
                         + (pds_pkg::QW'(r5_hl) << (CW + 1))
                         + pds_pkg::QW'(r5_ll);
            r6_root.m   <= r5_len2;
        end else begin
            r6_root.rem <= pds_pkg::QW'(r5_qpt);
            r6_root.m   <= PW'(1);
        end
    end

    assign w_chain[0] = r6_root;

    generate
        for (genvar g = 0; g < pds_pkg::RW; g++) begin : g_root
            pds_root_stage #(
                .BIT(pds_pkg::RW - 1 - g)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_stage (w_chain[g]),
                .o_stage (w_chain[g + 1])
            );
        end
    endgenerate

    assign o_valid        = w_chain[pds_pkg::RW].valid;
    assign o_distance     = w_chain[pds_pkg::RW].root[pds_pkg::DW-1:0];
    assign o_nearest_part = w_chain[pds_pkg::RW].part;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted beat did not emerge after pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without a matching start beat");

    a_unit_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r6_root.valid && r6_root.part != pds_pkg::PART_MID) |-> (r6_root.m == PW'(1)))
        else $error("end point case entered root with non-unit divisor");

endmodule

// ===== hdl/pds_root_stage.sv =====
// ----------------------------------------------------------------------------
// pds_root_stage: one bit of the scaled square root
// Settles root bit BIT: largest root with root*root*m <= radicand.
// ----------------------------------------------------------------------------
module pds_root_stage #(
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pds_pkg::t_root i_stage,
    output pds_pkg::t_root o_stage
);

    pds_pkg::t_root r_stage;
    pds_pkg::t_root n_stage;
    logic [pds_pkg::QW-1:0] delta;
    logic take;

    // (r + 2^b)^2 m - r^2 m = r m 2^(b+1) + m 2^(2b)
    always_comb begin
        delta = (pds_pkg::QW'(i_stage.acc) << (BIT + 1))
              + (pds_pkg::QW'(i_stage.m) << (2 * BIT));
        take  = (delta <= i_stage.rem);
        n_stage = i_stage;
        if (take) begin
            n_stage.rem  = i_stage.rem - delta;
            n_stage.acc  = i_stage.acc + (pds_pkg::AW'(i_stage.m) << BIT);
            n_stage.root = i_stage.root | (pds_pkg::RW'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.part <= n_stage.part;
        r_stage.rem  <= n_stage.rem;
        r_stage.acc  <= n_stage.acc;
        r_stage.m    <= n_stage.m;
        r_stage.root <= n_stage.root;
    end

    assign o_stage = r_stage;

endmodule

// ===== tb/tb_point_segment_distance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_segment_distance_top: self-checking bench for point to segment
// Drives random and corner-case geometry queries and checks each reported
// distance and nearest part against an exact in-bench calculation.
// ----------------------------------------------------------------------------
module tb_point_segment_distance_top;

    typedef struct packed {
        logic signed [31:0] px, py, sx, sy, ex, ey;
    } t_query;

    typedef struct packed {
        logic [pds_pkg::DW-1:0] distance;
        logic [1:0]             part;
    } t_answer;

    localparam int WATCHDOG = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_start_x = '0;
    logic signed [31:0] i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic o_valid;
    logic [pds_pkg::DW-1:0] o_distance;
    logic [1:0] o_nearest_part;

    t_query  query_q[$];
    t_answer answer_q[$];
    int      n_fail = 0;
    int      idle_cnt = 0;
    bit      feed_done = 0;
    bit      drain_req = 0;

    always #6 i_clk = ~i_clk;

    point_segment_distance_top dut (.*);

    // largest r below 2^34 with r*r*m <= q
    function automatic logic [33:0] isqrt_scaled(logic [199:0] q, logic [199:0] m);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if (200'(c) * 200'(c) * m <= q) r = c;
        end
        return r;
    endfunction

    function automatic t_answer nearest_distance(t_query t);
        logic signed [33:0] dx, dy, ux, uy, wx, wy;
        logic signed [71:0] dot, len2, cr;
        t_answer a;
        dx = 34'(t.ex) - 34'(t.sx);
        dy = 34'(t.ey) - 34'(t.sy);
        ux = 34'(t.px) - 34'(t.sx);
        uy = 34'(t.py) - 34'(t.sy);
        wx = 34'(t.px) - 34'(t.ex);
        wy = 34'(t.py) - 34'(t.ey);
        len2 = 72'(dx) * 72'(dx) + 72'(dy) * 72'(dy);
        dot = 72'(ux) * 72'(dx) + 72'(uy) * 72'(dy);
        if (dx == 0 && dy == 0) begin
            a.part = pds_pkg::PART_DEGEN;
            a.distance = pds_pkg::DW'(isqrt_scaled(
                200'(72'(ux) * 72'(ux) + 72'(uy) * 72'(uy)), 200'd1));
        end else if (dot < 0) begin
            a.part = pds_pkg::PART_START;
            a.distance = pds_pkg::DW'(isqrt_scaled(
                200'(72'(ux) * 72'(ux) + 72'(uy) * 72'(uy)), 200'd1));
        end else if (dot > len2) begin
            a.part = pds_pkg::PART_END;
            a.distance = pds_pkg::DW'(isqrt_scaled(
                200'(72'(wx) * 72'(wx) + 72'(wy) * 72'(wy)), 200'd1));
        end else begin
            a.part = pds_pkg::PART_MID;
            cr = 72'(ux) * 72'(dy) - 72'(uy) * 72'(dx);
            if (cr < 0) cr = -cr;
            a.distance = pds_pkg::DW'(isqrt_scaled(200'(cr) * 200'(cr), 200'(len2)));
        end
        return a;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task automatic add_query(logic [31:0] px, py, sx, sy, ex, ey);
        t_query t;
        t = '{px, py, sx, sy, ex, ey};
        query_q.push_back(t);
    endtask

    initial begin
        logic [31:0] sx, sy, ex, ey, px, py;
        logic [31:0] mx, mn;
        int k;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        // degenerate, both clamps, exact ends, interior and extremes
        add_query(0, 0, 0, 0, 0, 0);
        add_query(32'h1_0000, 32'h2_0000, 5, 5, 5, 5);
        add_query(mx, mx, mn, mn, mn, mn);
        add_query(mn, mn, mx, mx, mx, mx);
        add_query(-32'sh1_0000, 0, 0, 0, 32'h4_0000, 0);
        add_query(32'h5_0000, 32'h1_0000, 0, 0, 32'h4_0000, 0);
        add_query(0, 32'h3_0000, 0, 0, 32'h4_0000, 0);
        add_query(32'h4_0000, 32'h3_0000, 0, 0, 32'h4_0000, 0);
        add_query(32'h2_0000, 32'h3_0000, 0, 0, 32'h4_0000, 0);
        add_query(mx, mn, mn, mx, mx, mx);
        add_query(mn, mx, mx, mn, mn, mn);
        add_query(mx, mx, mn, mn, mx, mx);
        add_query(mn, mx, mn, mn, mx, mx);
        add_query(0, 0, mn, mx, mx, mn);
        add_query(mx, mn, mn, mn, mx, mx);
        add_query(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 0, 1, 32'hFFFF_FFFF);
        add_query(1, 0, 0, 0, 1, 1);
        add_query(0, 1, 1, 0, 0, 0);
        for (k = 0; k < 1040; k++) begin
            sx = rand_coord(); sy = rand_coord();
            ex = $urandom_range(0, 15) == 0 ? sx : rand_coord();
            ey = $urandom_range(0, 15) == 0 ? sy : rand_coord();
            px = rand_coord(); py = rand_coord();
            // bias toward points near the segment so every part shows up
            if ($urandom_range(0, 2) == 0) begin
                px = sx + 32'((64'($signed(ex - sx)) * $urandom_range(0, 4)) >>> 1);
                py = sy + 32'((64'($signed(ey - sy)) * $urandom_range(0, 4)) >>> 1)
                     + 32'($urandom_range(0, 1000));
            end
            add_query(px, py, sx, sy, ex, ey);
        end
        feed_done = 1;
    end

    // driver: one beat per item, random gap before each
    int gap = 0;
    int sent = 0;
    always @(negedge i_clk) begin
        t_query t;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy && query_q.size() == 0) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (drain_req) begin
                start <= 1'b0;
                if (answer_q.size() == 0) drain_req = 0;
            end else if (gap > 0) begin
                start <= 1'b0;
                gap--;
            end else if (query_q.size() > 0) begin
                t = query_q.pop_front();
                {i_point_x, i_point_y, i_start_x, i_start_y, i_end_x, i_end_y} <= t;
                start <= 1'b1;
                answer_q.push_back(nearest_distance(t));
                sent++;
                if (sent == 300) drain_req = 1;
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
                if (sent > 600 && sent < 700) gap = 0;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, check each strobe
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                $error("unexpected result distance=%0d part=%0d", o_distance, o_nearest_part);
                n_fail++;
            end else begin
                exp_a = answer_q.pop_front();
                if (o_distance !== exp_a.distance) begin
                    $error("distance: expected %0d actual %0d", exp_a.distance, o_distance);
                    n_fail++;
                end
                if (o_nearest_part !== exp_a.part) begin
                    $error("nearest_part: expected %0d actual %0d", exp_a.part,
                           o_nearest_part);
                    n_fail++;
                end
            end
        end
    end

    // watchdog: count cycles with no beat in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("tb_point_segment_distance_top NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (feed_done && query_q.size() == 0 && !start && answer_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (n_fail == 0 && answer_q.size() == 0) begin
            $display("tb_point_segment_distance_top OK");
        end else begin
            $display("tb_point_segment_distance_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pds_pkg.sv
hdl/pds_root_stage.sv
hdl/point_segment_distance_top.sv
tb/tb_point_segment_distance_top.sv
